/* rtl/core/interpolating_delay_line_assert.svh */
// Assertion macros for the delay line checker.
`ifndef INTERPOLATING_DELAY_LINE_ASSERT_SVH
`define INTERPOLATING_DELAY_LINE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define IDL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("delay line check failed");

// Same, but also checked across reset.
`define IDL_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("delay line reset check failed");

`endif

/* rtl/core/idl_pkg.sv */
// Shared constants, types and codes of the interpolating delay line.
package idl_pkg;

  localparam int DEPTH     = 4096;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int FRAC_BITS = 16;

  localparam int SMP_W = 16;
  localparam int DLY_W = 28;
  localparam int CFG_W = 12;
  localparam int H_W   = 16;

  // Interpolation datapath widths
  localparam int CB_W = SMP_W + 1;
  localparam int P_W  = SMP_W + 4;
  localparam int Q_W  = SMP_W + 2;
  localparam int IN_W = P_W + H_W + 1;
  localparam int HC_W = H_W + 2;
  localparam int S_W  = IN_W + HC_W - 1;
  localparam int SS_W = S_W - H_W;
  localparam int U_W  = SS_W + H_W + 2;
  localparam int R_W  = U_W - 33 + 1;

  localparam int SH_DN = (FRAC_BITS >= H_W) ? FRAC_BITS - H_W : 0;
  localparam int SH_UP = (FRAC_BITS < H_W) ? H_W - FRAC_BITS : 0;

  localparam logic [DLY_W-1:0] DLY_LO = DLY_W'((longint'(1) << FRAC_BITS) + 1);
  localparam logic [DLY_W-1:0] DLY_HI = DLY_W'(longint'(DEPTH - 3) << FRAC_BITS);

  localparam logic signed [U_W-1:0]  ROUND_HALF = U_W'(64'sh1_0000_0000);
  localparam logic signed [HC_W-1:0] H_ONE      = HC_W'(64'sd65536);
  localparam logic signed [R_W-1:0]  SAT_MAX    = R_W'(64'sd32767);
  localparam logic signed [R_W-1:0]  SAT_MIN    = R_W'(-64'sd32768);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_FIX,
    S_RD_B,
    S_RD_C,
    S_RD_A,
    S_RD_D,
    S_LAST
  } seq_state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [SMP_W-1:0]  wdata;
  } store_req_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] fix;
    logic signed [SMP_W-1:0] a;
    logic signed [SMP_W-1:0] b;
    logic signed [SMP_W-1:0] c;
    logic signed [SMP_W-1:0] d;
    logic [H_W-1:0]          h;
  } taps_t;

endpackage

/* rtl/core/idl_store.sv */
// Single-port sample memory with a fill count standing in for the cleared state.
module idl_store import idl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  store_req_t              req,
  output logic signed [SMP_W-1:0] rdata
);

  logic [SMP_W-1:0] mem [DEPTH];
  logic [SMP_W-1:0] q;
  logic             hit;
  logic [ADDR_W:0]  fill;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      q <= mem[req.addr];
    end
  end

  // Writes run in address order from zero, so entries at or above fill were never written.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      hit  <= 1'b0;
    end else begin
      if (req.we && fill != (ADDR_W + 1)'(DEPTH)) begin
        fill <= fill + 1'b1;
      end
      if (req.re) begin
        hit <= ({1'b0, req.addr} < fill);
      end
    end
  end

  assign rdata = hit ? signed'(q) : '0;

endmodule

/* rtl/core/idl_seq.sv */
// Sequencer: writes each item, then reads the fixed tap and four neighbors.
module idl_seq import idl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] sample_in,
  input  logic [DLY_W-1:0]        delay_in,
  output store_req_t              req,
  input  logic signed [SMP_W-1:0] rdata,
  input  logic                    busy,
  output logic                    launch,
  output taps_t                   taps
);

  seq_state_t state, state_next;

  logic [CFG_W-1:0]        fixed_delay;
  logic [ADDR_W-1:0]       cur;
  logic [ADDR_W-1:0]       base;
  logic [ADDR_W-1:0]       ip;
  logic [H_W-1:0]          h;
  logic signed [SMP_W-1:0] fix_s, a_s, b_s, c_s;

  logic                    accept;
  logic [DLY_W-1:0]        dly;
  logic [FRAC_BITS-1:0]    fr;
  logic [ADDR_W-1:0]       fd;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    rd_en;

  assign accept = in_valid && in_ready;

  // Clamp the variable delay and split it into whole and fractional parts
  always_comb begin
    if (delay_in < DLY_LO) begin
      dly = DLY_LO;
    end else if (delay_in > DLY_HI) begin
      dly = DLY_HI;
    end else begin
      dly = delay_in;
    end
    fr = dly[FRAC_BITS-1:0];
  end

  always_comb begin
    if (32'(fixed_delay) > 32'(DEPTH - 1)) begin
      fd = ADDR_W'(DEPTH - 1);
    end else begin
      fd = ADDR_W'(fixed_delay);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_RD_FIX;
      S_RD_FIX: state_next = S_RD_B;
      S_RD_B:   state_next = S_RD_C;
      S_RD_C:   state_next = S_RD_A;
      S_RD_A:   state_next = S_RD_D;
      S_RD_D:   state_next = S_LAST;
      S_LAST: begin
        if (!busy) begin
          state_next = accept ? S_RD_FIX : S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    launch   = 1'b0;
    rd_en    = 1'b0;
    rd_addr  = base;
    unique case (state)
      S_IDLE:   in_ready = 1'b1;
      S_RD_FIX: begin
        rd_en   = 1'b1;
        rd_addr = base - fd;
      end
      S_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = base - ip;
      end
      S_RD_C: begin
        rd_en   = 1'b1;
        rd_addr = base - (ip + 1'b1);
      end
      S_RD_A: begin
        rd_en   = 1'b1;
        rd_addr = base - (ip - 1'b1);
      end
      S_RD_D: begin
        rd_en   = 1'b1;
        rd_addr = base - (ip + 2'd2);
      end
      S_LAST: begin
        launch   = !busy;
        in_ready = !busy;
      end
      default: ;
    endcase
  end

  assign req.re    = rd_en;
  assign req.we    = accept;
  assign req.addr  = accept ? cur : rd_addr;
  assign req.wdata = sample_in;

  // The d neighbor arrives in the last state; the store holds it while stalled
  assign taps.fix = fix_s;
  assign taps.a   = a_s;
  assign taps.b   = b_s;
  assign taps.c   = c_s;
  assign taps.d   = rdata;
  assign taps.h   = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= '0;
      fixed_delay <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        fixed_delay <= cfg_data;
      end
      if (accept) begin
        cur <= cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      base <= cur;
      ip   <= dly[FRAC_BITS +: ADDR_W];
      h    <= H_W'((32'(fr) >> SH_DN) << SH_UP);
    end
    case (state)
      S_RD_B: fix_s <= rdata;
      S_RD_C: b_s   <= rdata;
      S_RD_A: c_s   <= rdata;
      S_RD_D: a_s   <= rdata;
      default: ;
    endcase
  end

endmodule

/* rtl/core/idl_interp.sv */
// Four-point interpolation datapath with rounding, saturation and the output register.
module idl_interp import idl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    launch,
  input  taps_t                   taps,
  output logic                    busy,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] fixed_tap,
  output logic signed [SMP_W-1:0] interp_tap
);

  logic v1, v2, v3, v4;

  logic signed [CB_W-1:0]  cb0, cb1, cb2;
  logic signed [P_W-1:0]   p0, p1;
  logic signed [Q_W-1:0]   q0, q1;
  logic signed [SMP_W-1:0] b1, b2, b3, b4;
  logic signed [SMP_W-1:0] f1, f2, f3, f4;
  logic [H_W-1:0]          h1, h2, h3;
  logic signed [IN_W-1:0]  inner0, inner2;
  logic signed [HC_W-1:0]  hc;
  logic signed [S_W-1:0]   s0;
  logic signed [SS_W-1:0]  ss3;
  logic signed [U_W-1:0]   u0, u4;
  logic signed [R_W-1:0]   r0;

  assign busy = v1 || v2 || v3 || v4 || out_valid;

  // Difference terms of the polynomial
  always_comb begin
    cb0 = CB_W'(taps.c) - CB_W'(taps.b);
    p0  = P_W'(taps.a) - P_W'(taps.d) + P_W'(cb0) + P_W'(cb0) + P_W'(cb0);
    q0  = Q_W'(taps.b) - Q_W'(taps.a) - Q_W'(cb0);
  end

  always_comb begin
    inner0 = (IN_W'(p1) * IN_W'(signed'({1'b0, h1}))) + (IN_W'(q1) <<< 16);
    hc     = H_ONE - signed'(HC_W'({2'b00, h2}));
    s0     = (S_W'(cb2) <<< 33) + (S_W'(inner2) * S_W'(hc));
    u0     = U_W'(ss3) * U_W'(signed'({1'b0, h3}));
    r0     = R_W'(b4) + R_W'((u4 + ROUND_HALF) >>> 33);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= launch;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      // A launch waits for an empty unit, so the output register is free here
      if (v4) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (launch) begin
      p1  <= p0;
      q1  <= q0;
      cb1 <= cb0;
      b1  <= taps.b;
      f1  <= taps.fix;
      h1  <= taps.h;
    end
    if (v1) begin
      inner2 <= inner0;
      cb2    <= cb1;
      b2     <= b1;
      f2     <= f1;
      h2     <= h1;
    end
    if (v2) begin
      ss3 <= SS_W'(s0 >>> 16);
      b3  <= b2;
      f3  <= f2;
      h3  <= h2;
    end
    if (v3) begin
      u4 <= u0;
      b4 <= b3;
      f4 <= f3;
    end
    if (v4) begin
      fixed_tap <= f4;
      if (r0 > SAT_MAX) begin
        interp_tap <= SMP_W'(SAT_MAX);
      end else if (r0 < SAT_MIN) begin
        interp_tap <= SMP_W'(SAT_MIN);
      end else begin
        interp_tap <= SMP_W'(r0);
      end
    end
  end

endmodule

/* rtl/core/interpolating_delay_line.sv */
// Top level of the interpolating delay line.
//
// Input channel (in_valid/in_ready) takes one item: sample_in and delay_in.
// Each item writes sample_in to a 4096-entry circular store, then yields one
// output item (out_valid/out_ready) with fixed_tap, the sample written
// fixed_delay items ago, and interp_tap, a four-point interpolation at the
// clamped fractional delay, rounded and saturated to 16 bits.
// The user must write fixed_delay through cfg_valid/cfg_ready/cfg_data only
// while idle; the block itself leaves this unchecked. The single store port
// sets the item rate: one write and five reads (fixed tap plus four neighbors)
// per item; an item's taps are all read before it is launched to interpolate.
// A stalled receiver holds the output item; the next input item is still
// taken and read, then waits until the output register frees up.
// Reset clears the write index, fixed_delay and the fill count; entries not
// yet written since reset read as zero, so no clearing pass is needed.
module interpolating_delay_line import idl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [SMP_W-1:0] sample_in,
  input  logic [DLY_W-1:0]        delay_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SMP_W-1:0] fixed_tap,
  output logic signed [SMP_W-1:0] interp_tap
);

  store_req_t              req;
  logic signed [SMP_W-1:0] rdata;
  logic                    busy;
  logic                    launch;
  taps_t                   taps;

  assign cfg_ready = 1'b1;

  idl_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  idl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .sample_in (sample_in),
    .delay_in  (delay_in),
    .req       (req),
    .rdata     (rdata),
    .busy      (busy),
    .launch    (launch),
    .taps      (taps)
  );

  idl_interp u_interp (
    .clk        (clk),
    .rst        (rst),
    .launch     (launch),
    .taps       (taps),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fixed_tap  (fixed_tap),
    .interp_tap (interp_tap)
  );

endmodule

/* rtl/core/idl_checker.sv */
// Port-level checker for the interpolating delay line, bound to the top level.
`include "interpolating_delay_line_assert.svh"

module idl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] fixed_tap,
  input logic [15:0] interp_tap
);

  `IDL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
  `IDL_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(fixed_tap) && $stable(interp_tap))
  `IDL_ASSERT_NEXT(a_busy_after_item, in_valid && in_ready, !in_ready)
  `IDL_ASSERT_NEXT_ALWAYS(a_reset_empty, rst, !out_valid)

endmodule

bind interpolating_delay_line idl_checker u_idl_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for the interpolating delay line: predicts both taps per sample and compares.
module tb_top;
  import idl_pkg::*;

  localparam int          HALF_PERIOD = 10;
  localparam int          CYCLE_LIMIT = 300000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          PHASE_ITEMS = 160;
  localparam int          NUM_PHASES  = 6;
  localparam int          LONG_HOLD_PHASE = 4;
  localparam int          PAUSE_PHASE = 5;
  localparam int          TAIL_CYCLES = 30;
  localparam logic [CFG_W-1:0] CFG_MAX  = '1;
  localparam longint unsigned DELAY_MIN_Q = (64'd1 << FRAC_BITS) + 64'd1;
  localparam longint unsigned DELAY_MAX_Q = longint'(DEPTH - 3) << FRAC_BITS;
  localparam logic [DLY_W-1:0] DELAY_TOP = DLY_W'(DELAY_MAX_Q);
  localparam logic [DLY_W-1:0] ONE_Q     = DLY_W'(64'd1 << FRAC_BITS);

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_valid = 1'b0;
  logic [CFG_W-1:0]        cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic signed [SMP_W-1:0] sample_in = '0;
  logic [DLY_W-1:0]        delay_in  = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_ready;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [SMP_W-1:0] fixed_tap;
  logic signed [SMP_W-1:0] interp_tap;

  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_cnt = 0;

  class tap_predictor;
    typedef struct {
      logic signed [SMP_W-1:0] fixed_tap;
      logic signed [SMP_W-1:0] interp_tap;
    } tap_pair_t;

    logic [SMP_W-1:0] history [DEPTH];
    int unsigned      wr_pos;
    int unsigned      fix_delay;
    tap_pair_t        pending [$];
    int               errors;

    function new();
      foreach (history[k]) history[k] = '0;
      wr_pos    = 0;
      fix_delay = 0;
      errors    = 0;
    endfunction

    function void set_fixed_delay(logic [CFG_W-1:0] value);
      fix_delay = value;
    endfunction

    // Sample written k items ago; k = 0 is the one just stored.
    function longint sample_back(int unsigned k);
      return longint'($signed(history[(wr_pos + DEPTH - k % DEPTH) % DEPTH]));
    endfunction

    function void take_sample(logic signed [SMP_W-1:0] smp, logic [DLY_W-1:0] dly);
      longint unsigned dq;
      int unsigned     whole;
      int unsigned     fd;
      longint          h, a, b, c, d, cb, p, q, inner, s, u, r;
      tap_pair_t       t;
      history[wr_pos] = smp;
      fd = (fix_delay > DEPTH - 1) ? DEPTH - 1 : fix_delay;
      dq = dly;
      if (dq < DELAY_MIN_Q) dq = DELAY_MIN_Q;
      if (dq > DELAY_MAX_Q) dq = DELAY_MAX_Q;
      whole = int'(dq >> FRAC_BITS);
      h = longint'(dq % (64'd1 << FRAC_BITS));
      // bring the fraction to 16 bits, truncating any extra low bits
      if (FRAC_BITS >= 16) h = h >>> (FRAC_BITS - 16);
      else h = h << (16 - FRAC_BITS);
      b = sample_back(whole);
      c = sample_back(whole + 1);
      a = sample_back(whole - 1);
      d = sample_back(whole + 2);
      cb = c - b;
      p = a - d + 3 * cb;
      q = b - a - cb;
      inner = p * h + q * 65536;
      s = cb * (longint'(1) << 33) + inner * (65536 - h);
      s = s >>> 16;
      u = s * h;
      r = b + ((u + (longint'(1) << 32)) >>> 33);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      t.fixed_tap  = SMP_W'(sample_back(fd));
      t.interp_tap = SMP_W'(r);
      pending.push_back(t);
      wr_pos = (wr_pos + 1) % DEPTH;
    endfunction

    function void check_taps(logic signed [SMP_W-1:0] fx, logic signed [SMP_W-1:0] it);
      tap_pair_t t;
      if (pending.size() == 0) begin
        $error("unexpected output item: fixed_tap %0d interp_tap %0d", fx, it);
        errors++;
        return;
      end
      t = pending.pop_front();
      if (fx !== t.fixed_tap) begin
        $error("fixed_tap: expected %0d, got %0d", t.fixed_tap, fx);
        errors++;
      end
      if (it !== t.interp_tap) begin
        $error("interp_tap: expected %0d, got %0d", t.interp_tap, it);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending.size();
    endfunction
  endclass

  tap_predictor sb = new();

  interpolating_delay_line u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .delay_in   (delay_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .fixed_tap  (fixed_tap),
    .interp_tap (interp_tap)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready) sb.check_taps(fixed_tap, interp_tap);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_item(input logic signed [SMP_W-1:0] smp, input logic [DLY_W-1:0] dly,
                           input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= smp;
    delay_in  <= dly;
    do @(posedge clk); while (!in_ready);
    sb.take_sample(smp, dly);
  endtask

  task automatic send_random(input int idle_pct);
    logic signed [SMP_W-1:0] smp;
    logic [DLY_W-1:0]        dly;
    smp = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 16'sh7fff : 16'sh8000)
                                   : SMP_W'($urandom);
    case ($urandom_range(7))
      0: dly = DLY_W'($urandom);
      1: dly = DLY_W'($urandom_range(0, 3 << FRAC_BITS));
      2: dly = DLY_W'($urandom_range(int'(DELAY_TOP) - (4 << FRAC_BITS), (1 << DLY_W) - 1));
      default: dly = DLY_W'($urandom_range(0, 40 << FRAC_BITS));
    endcase
    send_item(smp, dly, idle_pct);
  endtask

  // Drop valid and hold until every predicted item has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic write_fixed_delay(input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_fixed_delay(value);
  endtask

  initial begin
    int fd_set    [NUM_PHASES] = '{3, 4095, 1, 0, 0, 37};
    int idle_set  [NUM_PHASES] = '{0, 69, 0, 22, 0, 22};
    int stall_set [NUM_PHASES] = '{0, 0, 69, 22, 0, 22};
    fd_set[3] = $urandom_range(0, int'(CFG_MAX));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // clamping at both ends of the variable delay, field extremes
    send_item(16'sh0000, '0, 0);
    send_item(16'sh7fff, ONE_Q, 0);
    send_item(16'sh8000, ONE_Q + 1'b1, 0);
    send_item(-16'sd1, '1, 0);
    send_item(16'sd1, DELAY_TOP, 0);
    send_item(-16'sd2, DELAY_TOP + 1'b1, 0);
    send_item(16'sd12345, 28'h001_8000, 0);
    send_item(-16'sd12345, 28'h002_ffff, 0);
    send_item(16'sh5555, 28'h002_8000, 0);
    send_item(-16'sh5556, 28'h003_0001, 0);
    send_item(16'sd300, 28'h001_ffff, 0);
    send_item(-16'sd300, 28'h004_4000, 0);
    // overshoot above the top, then below the bottom
    send_item(16'sh8000, 28'h001_8000, 0);
    send_item(16'sh7fff, 28'h001_8000, 0);
    send_item(16'sh7fff, 28'h001_8000, 0);
    send_item(16'sh8000, 28'h001_8000, 0);
    send_item(16'sh7fff, 28'h001_8000, 0);
    send_item(16'sh8000, 28'h001_8000, 0);
    send_item(16'sh8000, 28'h001_8000, 0);
    send_item(16'sh7fff, 28'h001_8000, 0);
    send_item(16'sh7fff, 28'h001_c000, 0);
    send_item(16'sh8000, 28'h001_4000, 0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      write_fixed_delay(CFG_W'(fd_set[ph]));
      stall_pct = stall_set[ph];
      // receiver blocks for a long stretch while items keep coming
      if (ph == LONG_HOLD_PHASE) hold_reqs <= hold_reqs + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == PAUSE_PHASE && n == PHASE_ITEMS / 2) wait_drained();
        send_random(idle_set[ph]);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/idl_pkg.sv
rtl/core/idl_store.sv
rtl/core/idl_seq.sv
rtl/core/idl_interp.sv
rtl/core/interpolating_delay_line.sv
rtl/core/idl_checker.sv
bench/tb_top.sv
